// ===== hdl/pdct_pkg.sv =====
// shared types and constants for the pair dedup and conflict table
package pdct_pkg;

  localparam int unsigned IdW           = 32;
  localparam int unsigned PairCountW    = 7;
  localparam int unsigned TableDepthDef = 64;

  // query travelling down the cell row
  typedef struct packed {
    logic           vld;
    logic           last;
    logic           dup;
    logic           clash;
    logic [IdW-1:0] star;
    logic [IdW-1:0] field;
  } probe_t;

  // one result item
  typedef struct packed {
    logic                  stored;
    logic                  duplicate;
    logic                  conflict;
    logic                  overflow;
    logic [PairCountW-1:0] pair_count;
    logic                  set_consistent;
    logic                  set_done;
  } res_t;

endpackage

// ===== hdl/pdct_cell.sv =====
// one table cell: holds a stored pair and checks the passing query against it
module pdct_cell import pdct_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  probe_t         probe_i,
  output probe_t         probe_o,
  input  logic           cmp_en_i,
  input  logic           wr_en_i,
  input  logic [IdW-1:0] wr_star_i,
  input  logic [IdW-1:0] wr_field_i
);

  logic [IdW-1:0] star_q;
  logic [IdW-1:0] field_q;
  logic           vld_q;
  probe_t         probe_q;
  probe_t         probe_d;
  logic           same_star;
  logic           same_field;

  assign same_star  = (star_q == probe_i.star);
  assign same_field = (field_q == probe_i.field);

  always_comb begin
    probe_d       = probe_i;
    probe_d.dup   = probe_i.dup | (cmp_en_i & same_star & same_field);
    probe_d.clash = probe_i.clash | (cmp_en_i & (same_star ^ same_field));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= probe_d.vld;
    end
  end

  // query payload, no reset needed; valid comes from vld_q
  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    if (wr_en_i) begin
      star_q  <= wr_star_i;
      field_q <= wr_field_i;
    end
  end

  always_comb begin
    probe_o     = probe_q;
    probe_o.vld = vld_q;
  end

endmodule

// ===== hdl/pair_dedup_conflict_table.sv =====
// top level: cell row, entry count, consistency flag and result registers
//
// pair_dedup_conflict_table
// input channel: in_valid_i / in_stall_o with star_id_i, field_id_i, last_pair_i
// output channel: out_valid_o / out_stall_i with one result item per input item
// an item is taken at a clock edge where valid is high and stall is low
// each accepted pair enters a row of TABLE_DEPTH cells, one stored pair per
// cell, and moves one cell per cycle; each cell folds its match into the
// duplicate and clash bits carried with the query
// the input stalls while a query walks through the cell row; one pair is in
// the row at a time
// the append into the next free cell and the count and flag update happen at
// the edge where the query leaves the last cell
// a result waiting on a stalled receiver does not block the input; a second
// result goes to a skid register, and the input stalls while that is full
// reset: entry count zero, set flag one, no item in flight, no result pending;
// stored pairs are not cleared, cells at or above the count are never compared
// last_pair: the result shows the set state, then count and flag restart
module pair_dedup_conflict_table import pdct_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [IdW-1:0]        star_id_i,
  input  logic [IdW-1:0]        field_id_i,
  input  logic                  last_pair_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  stored_o,
  output logic                  duplicate_o,
  output logic                  conflict_o,
  output logic                  overflow_o,
  output logic [PairCountW-1:0] pair_count_o,
  output logic                  set_consistent_o,
  output logic                  set_done_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  // control state
  logic            busy_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            flag_q;
  logic            flag_d;
  logic            out_vld_q;
  logic            skid_vld_q;
  res_t            out_q;
  res_t            skid_q;
  res_t            res;

  // cell row wiring
  probe_t                 chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] cmp_en;
  logic [TABLE_DEPTH-1:0] wr_sel;

  logic            accept;
  logic            emerge;
  logic            take;
  logic            room;
  logic            is_dup;
  logic            is_clash;
  logic            do_store;
  logic [CntW-1:0] count_new;
  probe_t          tail;

  assign in_stall_o = busy_q | skid_vld_q;
  assign accept     = in_valid_i & ~in_stall_o;
  assign take       = out_vld_q & ~out_stall_i;

  // query entering the first cell
  always_comb begin
    chain[0].vld   = accept;
    chain[0].last  = last_pair_i;
    chain[0].dup   = 1'b0;
    chain[0].clash = 1'b0;
    chain[0].star  = star_id_i;
    chain[0].field = field_id_i;
  end

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    localparam logic [CntW-1:0] IdxC = CntW'(gi);

    // only cells below the count hold pairs of this set
    assign cmp_en[gi] = (IdxC < count_q);
    assign wr_sel[gi] = do_store & (count_q == IdxC);

    pdct_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .probe_i    (chain[gi]),
      .probe_o    (chain[gi+1]),
      .cmp_en_i   (cmp_en[gi]),
      .wr_en_i    (wr_sel[gi]),
      .wr_star_i  (tail.star),
      .wr_field_i (tail.field)
    );
  end

  // query leaving the row: decide and build the result
  assign tail      = chain[TABLE_DEPTH];
  assign emerge    = tail.vld;
  assign is_dup    = tail.dup;
  assign is_clash  = ~tail.dup & tail.clash;
  assign room      = (count_q < DepthC);
  assign do_store  = emerge & ~is_dup & room;
  assign count_new = do_store ? count_q + CntW'(1) : count_q;

  always_comb begin
    res.stored         = ~is_dup & room;
    res.duplicate      = is_dup;
    res.conflict       = is_clash;
    res.overflow       = ~is_dup & ~room;
    res.pair_count     = PairCountW'(count_new);
    res.set_consistent = flag_q & ~is_clash;
    res.set_done       = tail.last;
  end

  // set state after this item; last pair restarts the set
  always_comb begin
    count_d = count_q;
    flag_d  = flag_q;
    if (emerge) begin
      if (tail.last) begin
        count_d = '0;
        flag_d  = 1'b1;
      end else begin
        count_d = count_new;
        flag_d  = res.set_consistent;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      count_q    <= '0;
      flag_q     <= 1'b1;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      flag_q  <= flag_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (emerge) begin
        busy_q <= 1'b0;
      end
      if (emerge) begin
        // skid is always empty here: input stalls while it is full
        if (!out_vld_q || take) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (take) begin
        out_vld_q  <= skid_vld_q;
        skid_vld_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (emerge) begin
      if (!out_vld_q || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (take && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign stored_o         = out_q.stored;
  assign duplicate_o      = out_q.duplicate;
  assign conflict_o       = out_q.conflict;
  assign overflow_o       = out_q.overflow;
  assign pair_count_o     = out_q.pair_count;
  assign set_consistent_o = out_q.set_consistent;
  assign set_done_o       = out_q.set_done;

  // checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid result without output result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count beyond table depth");

  a_emerge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emerge |-> busy_q)
    else $error("query left the row with no item in flight");

  a_no_emerge_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emerge |-> !skid_vld_q)
    else $error("result arrived while skid register full");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted item not marked in flight");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $onehot({out_q.stored, out_q.duplicate, out_q.overflow}))
    else $error("result is not exactly one of stored, duplicate, overflow");

endmodule
